FILE: src/efr_pkg.sv
// Shared types and constants for the escaped API frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    localparam logic [7:0] START_CODE = 8'h7E;
    localparam logic [7:0] ESC_CODE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_GOOD = 2'd1,
        EV_FAIL = 2'd2,
        EV_LONG = 2'd3
    } efr_event_t;

    typedef struct packed {
        efr_event_t  event_res;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_type;
        logic [7:0]  data_length;
    } efr_result_t;

endpackage

`default_nettype wire

FILE: src/efr_parser.sv
// Frame parser: state registers and per-byte decode of escaped frames.
`timescale 1ns / 1ps
`default_nettype none

module efr_parser #(
    parameter int MAX_POSITION = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          rx_byte,
    output logic                     res_valid,
    output efr_pkg::efr_result_t     res
);

    localparam int PW = $clog2(MAX_POSITION + 2);

    logic [PW-1:0] pos_reg, pos_next;
    logic          esc_reg, esc_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    type_reg, type_next;

    logic [7:0]    dec_byte;
    logic [7:0]    sum_add;
    logic [8:0]    pos_wide;

    assign dec_byte = esc_reg ? (rx_byte ^ efr_pkg::ESC_XOR) : rx_byte;
    assign pos_wide = 9'(pos_reg);
    assign sum_add  = (pos_wide >= 9'd3) ? (sum_reg + dec_byte) : sum_reg;

    always_comb
    begin
        pos_next             = pos_reg;
        esc_next             = esc_reg;
        sum_next             = sum_reg;
        len_next             = len_reg;
        type_next            = type_reg;
        res_valid            = 1'b0;
        res.event_res        = efr_pkg::EV_DATA;
        res.data_byte        = 8'd0;
        res.byte_index       = 8'd0;
        res.frame_type       = type_reg;
        res.data_length      = 8'd0;

        if (rx_byte == efr_pkg::START_CODE)
        begin
            // start byte always opens a fresh frame
            pos_next = PW'(1);
            sum_next = 8'd0;
            esc_next = 1'b0;
        end
        else if (pos_reg == '0)
        begin
            // idle: drop the byte
        end
        else if (!esc_reg && rx_byte == efr_pkg::ESC_CODE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            sum_next = sum_add;
            if (pos_wide == 9'd1)
            begin
                pos_next = PW'(2);
            end
            else if (pos_wide == 9'd2)
            begin
                len_next = dec_byte;
                pos_next = PW'(3);
            end
            else if (pos_wide == 9'd3)
            begin
                type_next = dec_byte;
                pos_next  = PW'(4);
            end
            else if (pos_wide > 9'(MAX_POSITION))
            begin
                res_valid       = 1'b1;
                res.event_res   = efr_pkg::EV_LONG;
                res.data_length = 8'(pos_wide - 9'd4);
                pos_next        = '0;
                sum_next        = 8'd0;
            end
            else if (pos_wide == ({1'b0, len_reg} + 9'd3))
            begin
                res_valid       = 1'b1;
                res.data_length = 8'(pos_wide - 9'd4);
                if (sum_add == efr_pkg::SUM_GOOD)
                begin
                    res.event_res = efr_pkg::EV_GOOD;
                    res.data_byte = dec_byte;
                end
                else
                begin
                    res.event_res = efr_pkg::EV_FAIL;
                end
                pos_next = '0;
                sum_next = 8'd0;
            end
            else
            begin
                res_valid      = 1'b1;
                res.event_res  = efr_pkg::EV_DATA;
                res.data_byte  = dec_byte;
                res.byte_index = 8'(pos_wide - 9'd4);
                pos_next       = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            esc_reg  <= 1'b0;
            sum_reg  <= 8'd0;
            len_reg  <= 8'd0;
            type_reg <= 8'd0;
        end
        else if (take)
        begin
            pos_reg  <= pos_next;
            esc_reg  <= esc_next;
            sum_reg  <= sum_next;
            len_reg  <= len_next;
            type_reg <= type_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/efr_out_buf.sv
// Result register with skid stage between parser and output channel.
`timescale 1ns / 1ps
`default_nettype none

module efr_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire efr_pkg::efr_result_t push_data,
    output logic                      space,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output efr_pkg::efr_result_t      out_data
);

    logic                  main_valid_reg;
    logic                  skid_valid_reg;
    efr_pkg::efr_result_t  main_reg;
    efr_pkg::efr_result_t  skid_reg;
    logic                  pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // payload: advance skid into main on pop, else load where the push lands
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/escaped_api_frame_receiver.sv
// Top level of the escaped API frame receiver.
//
// Input channel: one raw serial byte (rx_byte) per transfer on in_valid /
// in_ready. Output channel: at most one result per input byte on
// out_valid / out_ready, carrying event_res (data, frame good, checksum
// failure, frame too long), data_byte, byte_index, frame_type and
// data_length as separate ports.
// A result is registered: it lands in the result register, or in the skid
// stage when the result register holds an item that is not taken in that
// cycle. Throughput: one byte per cycle while the skid stage is free, set
// by the combinational decode between parser state and result registers.
// Start, escape and header bytes produce no result; they only update the
// parser state.
// Reset (rst_n low, asynchronous) returns the parser to idle with the
// checksum, escape flag, stored length and type cleared, and empties the
// output stage.
// Stall: when out_ready is held low the result register holds its item and
// one further result lands in the skid stage; in_ready drops only while the
// skid stage is occupied, so at most two results wait.
`timescale 1ns / 1ps
`default_nettype none

module escaped_api_frame_receiver #(
    parameter int MAX_POSITION = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       event_res,
    output logic [7:0]       data_byte,
    output logic [7:0]       byte_index,
    output logic [7:0]       frame_type,
    output logic [7:0]       data_length
);

    logic                  take;
    logic                  res_valid;
    logic                  space;
    efr_pkg::efr_result_t  res;
    efr_pkg::efr_result_t  out_data;

    // accept a byte whenever the skid stage is free
    assign in_ready = space;
    assign take     = in_valid && in_ready;

    efr_parser #(
        .MAX_POSITION (MAX_POSITION)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold results here until the receiver takes them
    efr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign event_res   = out_data.event_res;
    assign data_byte   = out_data.data_byte;
    assign byte_index  = out_data.byte_index;
    assign frame_type  = out_data.frame_type;
    assign data_length = out_data.data_length;

endmodule

`default_nettype wire

FILE: src/efr_checker.sv
// Port-level checks for the escaped API frame receiver, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module efr_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  event_res,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  byte_index,
    input  wire logic [7:0]  data_length
);

    // a stalled result stays on the port
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(data_byte))
        else $error("output result changed while stalled");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == efr_pkg::EV_DATA |-> data_length == 8'd0)
        else $error("data event carries a frame length");

    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != efr_pkg::EV_DATA |-> byte_index == 8'd0)
        else $error("frame end event carries a byte index");

    a_fail_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == efr_pkg::EV_FAIL || event_res == efr_pkg::EV_LONG)
        |-> data_byte == 8'd0)
        else $error("failure event carries a data byte");

endmodule

bind escaped_api_frame_receiver efr_checker u_efr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .data_length (data_length)
);

`default_nettype wire
